>>> sv/m3iu_pkg.sv
`default_nettype none

package m3iu_pkg;

  // Command codes carried in the action field.
  localparam logic [3:0] ACT_LOAD_A  = 4'd0;
  localparam logic [3:0] ACT_LOAD_B  = 4'd1;
  localparam logic [3:0] ACT_ADD     = 4'd2;
  localparam logic [3:0] ACT_SUB     = 4'd3;
  localparam logic [3:0] ACT_SCALE_A = 4'd4;
  localparam logic [3:0] ACT_SCALE_B = 4'd5;
  localparam logic [3:0] ACT_MUL     = 4'd6;
  localparam logic [3:0] ACT_TRANS_A = 4'd7;
  localparam logic [3:0] ACT_TRANS_B = 4'd8;
  localparam logic [3:0] ACT_READ    = 4'd9;
  localparam logic [3:0] ACT_DIAG    = 4'd10;
  localparam logic [3:0] ACT_IDENT   = 4'd11;
  localparam logic [3:0] ACT_SYMM    = 4'd12;

  // Matrix selector codes.
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;

  // Operations of the shared arithmetic unit.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MAC  = 2'd2;
  localparam logic [1:0] OP_PASS = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic [1:0]         which;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               flag;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

endpackage

`default_nettype wire

>>> sv/m3iu_ram.sv
`default_nettype none

module m3iu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

>>> sv/m3iu_mat.sv
`default_nettype none

module m3iu_mat #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  // An entry that has not been written since reset reads as zero.
  logic [DEPTH-1:0] vld;
  logic             vld0;
  logic             vld1;
  logic [WIDTH-1:0] q0;
  logic [WIDTH-1:0] q1;

  m3iu_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(q0),
    .rdata1(q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld0 <= vld[raddr0];
      vld1 <= vld[raddr1];
    end
  end

  assign rdata0 = vld0 ? q0 : '0;
  assign rdata1 = vld1 ? q1 : '0;

endmodule

`default_nettype wire

>>> sv/m3iu_alu.sv
`default_nettype none

module m3iu_alu #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  m3iu_pkg::alu_ctl_t  ctl,
  input  logic [WIDTH-1:0]    a,
  input  logic [WIDTH-1:0]    b,
  input  logic [WIDTH-1:0]    c,
  output logic                done,
  output logic [WIDTH-1:0]    res
);

  import m3iu_pkg::*;

  // Multiplier operand width; wider elements are split into partial products.
  localparam int HW  = (WIDTH > 32) ? 32 : WIDTH;
  localparam int NPP = (WIDTH > 32) ? 3 : 1;
  localparam int CW  = $clog2(NPP + 1);
  localparam logic [CW-1:0] NPP_C = CW'(NPP);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [WIDTH-1:0]  a_r;
  logic [WIDTH-1:0]  b_r;
  logic [WIDTH-1:0]  a_sh;
  logic [WIDTH-1:0]  b_sh;
  logic [HW-1:0]     mul_x;
  logic [HW-1:0]     mul_y;
  logic [2*HW-1:0]   prod;
  logic [2*HW-1:0]   pp_r;
  logic [WIDTH-1:0]  pp_lo;
  logic [WIDTH-1:0]  term;
  logic [WIDTH-1:0]  sum;

  assign a_sh = a_r >> HW;
  assign b_sh = b_r >> HW;

  // Step zero multiplies the low halves; the two cross terms follow when split.
  always_comb begin
    case (cnt)
      CW'(0): begin
        mul_x = a_r[HW-1:0];
        mul_y = b_r[HW-1:0];
      end
      CW'(1): begin
        mul_x = a_r[HW-1:0];
        mul_y = b_sh[HW-1:0];
      end
      default: begin
        mul_x = a_sh[HW-1:0];
        mul_y = b_r[HW-1:0];
      end
    endcase
  end

  assign prod  = (2*HW)'(mul_x) * (2*HW)'(mul_y);
  assign pp_lo = pp_r[WIDTH-1:0];
  assign term  = (cnt == CW'(1)) ? pp_lo : (pp_lo << HW);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= (ctl.op == OP_MAC);
        done <= (ctl.op != OP_MAC);
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == NPP_C) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= a;
      b_r <= b;
      unique case (ctl.op)
        OP_ADD:  sum <= a + b;
        OP_SUB:  sum <= a - b;
        OP_PASS: sum <= a;
        OP_MAC:  sum <= c;
      endcase
    end else if (busy) begin
      if (cnt < NPP_C) begin
        pp_r <= prod;
      end
      if (cnt != '0) begin
        sum <= sum + term;
      end
    end
  end

  assign res = sum;

endmodule

`default_nettype wire

>>> sv/matrix_3x3_integer_unit.sv
`default_nettype none

// Holds three DIM x DIM integer matrices A, B and C (all zero after reset) and
// runs one command transaction at a time: loading an element of A or B leaves
// the command port open, undefined action codes are ignored, and every other
// command closes the command port until it is finished. Element work goes
// through one shared add/subtract/multiply-accumulate/pass unit, element by
// element, reading each element from the registered matrix memories in the
// state before it is used. The multiply-accumulate unit forms one partial
// product for elements up to 32 bits and three above. Read-outs and matrix
// tests wait while the result side stalls. Results wait in an output register.
module matrix_3x3_integer_unit #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  m3iu_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output m3iu_pkg::rsp_t  rsp
);

  import m3iu_pkg::*;

  localparam int NELEM = DIM * DIM;
  localparam int AW    = $clog2(NELEM);
  localparam int IW    = $clog2(DIM);
  localparam logic [IW-1:0] IMAX = IW'(DIM - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [3:0]            act;
  logic [1:0]            sel;
  logic [ELEM_WIDTH-1:0] val_w;
  logic [IW-1:0]         i;
  logic [IW-1:0]         j;
  logic [IW-1:0]         k;
  logic [ELEM_WIDTH-1:0] acc;
  logic                  ok;

  logic                  cmd_acc;
  logic                  rsp_free;
  logic                  rsp_load;
  logic                  last_e;
  logic                  adv;
  logic                  op_calc;
  logic                  op_read;
  logic                  op_test;
  logic                  op_mul;
  logic                  pass;

  logic [AW-1:0]         addr_e;
  logic [AW-1:0]         addr_t;
  logic [AW-1:0]         addr_ik;
  logic [AW-1:0]         addr_kj;
  logic [AW-1:0]         a_ra0;
  logic [AW-1:0]         b_ra0;
  logic [AW-1:0]         ld_addr;
  logic [ELEM_WIDTH-1:0] ld_data;
  logic                  load_ok;
  logic                  a_we;
  logic                  b_we;
  logic                  c_we;

  logic [ELEM_WIDTH-1:0] a_q0;
  logic [ELEM_WIDTH-1:0] a_q1;
  logic [ELEM_WIDTH-1:0] b_q0;
  logic [ELEM_WIDTH-1:0] b_q1;
  logic [ELEM_WIDTH-1:0] c_q0;
  logic [ELEM_WIDTH-1:0] c_q1;
  logic [ELEM_WIDTH-1:0] m0;
  logic [ELEM_WIDTH-1:0] m1;

  alu_ctl_t              alu_ctl;
  logic [ELEM_WIDTH-1:0] alu_a;
  logic [ELEM_WIDTH-1:0] alu_b;
  logic                  alu_done;
  logic [ELEM_WIDTH-1:0] alu_res;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign last_e    = (i == IMAX) && (j == IMAX);

  always_comb begin
    op_calc = 1'b0;
    op_read = 1'b0;
    op_test = 1'b0;
    unique case (act) inside
      ACT_ADD, ACT_SUB, ACT_SCALE_A, ACT_SCALE_B, ACT_MUL, ACT_TRANS_A,
      ACT_TRANS_B:                    op_calc = 1'b1;
      ACT_READ:                       op_read = 1'b1;
      ACT_DIAG, ACT_IDENT, ACT_SYMM:  op_test = 1'b1;
      default:                        op_calc = 1'b0;
    endcase
  end
  assign op_mul = (act == ACT_MUL);

  // Element addresses from the row, column and inner-product counters.
  assign addr_e  = AW'(int'(i) * DIM + int'(j));
  assign addr_t  = AW'(int'(j) * DIM + int'(i));
  assign addr_ik = AW'(int'(i) * DIM + int'(k));
  assign addr_kj = AW'(int'(k) * DIM + int'(j));

  assign a_ra0 = op_mul ? addr_ik : ((act == ACT_TRANS_A) ? addr_t : addr_e);
  assign b_ra0 = op_mul ? addr_kj : ((act == ACT_TRANS_B) ? addr_t : addr_e);

  assign load_ok = (int'(cmd.row) < DIM) && (int'(cmd.col) < DIM);
  assign ld_addr = AW'(int'(cmd.row) * DIM + int'(cmd.col));
  assign ld_data = ELEM_WIDTH'($signed(cmd.value));
  assign a_we    = cmd_acc && (cmd.action == ACT_LOAD_A) && load_ok;
  assign b_we    = cmd_acc && (cmd.action == ACT_LOAD_B) && load_ok;
  assign c_we    = (state == S_CALC) && alu_done && !(op_mul && (k != IMAX));

  m3iu_mat #(.WIDTH(ELEM_WIDTH), .DEPTH(NELEM)) u_mat_a (
    .clk   (clk),
    .rst   (rst),
    .we    (a_we),
    .waddr (ld_addr),
    .wdata (ld_data),
    .raddr0(a_ra0),
    .raddr1(addr_t),
    .rdata0(a_q0),
    .rdata1(a_q1)
  );

  m3iu_mat #(.WIDTH(ELEM_WIDTH), .DEPTH(NELEM)) u_mat_b (
    .clk   (clk),
    .rst   (rst),
    .we    (b_we),
    .waddr (ld_addr),
    .wdata (ld_data),
    .raddr0(b_ra0),
    .raddr1(addr_t),
    .rdata0(b_q0),
    .rdata1(b_q1)
  );

  m3iu_mat #(.WIDTH(ELEM_WIDTH), .DEPTH(NELEM)) u_mat_c (
    .clk   (clk),
    .rst   (rst),
    .we    (c_we),
    .waddr (addr_e),
    .wdata (alu_res),
    .raddr0(addr_e),
    .raddr1(addr_t),
    .rdata0(c_q0),
    .rdata1(c_q1)
  );

  // Selector values above B both pick C.
  assign m0 = (sel == SEL_A) ? a_q0 : ((sel == SEL_B) ? b_q0 : c_q0);
  assign m1 = (sel == SEL_A) ? a_q1 : ((sel == SEL_B) ? b_q1 : c_q1);

  always_comb begin
    case (act)
      ACT_DIAG:  pass = (i == j) || (m0 == '0);
      ACT_IDENT: pass = (i == j) ? (m0 == ELEM_WIDTH'(1)) : (m0 == '0);
      ACT_SYMM:  pass = (m0 == m1);
      default:   pass = 1'b1;
    endcase
  end

  always_comb begin
    alu_ctl.start = (state == S_DATA) && op_calc;
    unique case (act) inside
      ACT_ADD:                              alu_ctl.op = OP_ADD;
      ACT_SUB:                              alu_ctl.op = OP_SUB;
      ACT_SCALE_A, ACT_SCALE_B, ACT_MUL:    alu_ctl.op = OP_MAC;
      default:                              alu_ctl.op = OP_PASS;
    endcase
  end

  assign alu_a = ((act == ACT_SCALE_B) || (act == ACT_TRANS_B)) ? b_q0 : a_q0;
  assign alu_b = ((act == ACT_SCALE_A) || (act == ACT_SCALE_B)) ? val_w : b_q0;

  m3iu_alu #(.WIDTH(ELEM_WIDTH)) u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .c   (acc),
    .done(alu_done),
    .res (alu_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd.action) inside
            ACT_ADD, ACT_SUB, ACT_SCALE_A, ACT_SCALE_B, ACT_MUL, ACT_TRANS_A,
            ACT_TRANS_B, ACT_READ, ACT_DIAG, ACT_IDENT, ACT_SYMM:
              state_next = S_ISSUE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ISSUE: state_next = S_DATA;
      S_DATA: begin
        if (op_calc) begin
          state_next = S_CALC;
        end else if (op_read) begin
          if (rsp_free) begin
            state_next = last_e ? S_IDLE : S_ISSUE;
          end
        end else begin
          state_next = last_e ? S_OUT : S_ISSUE;
        end
      end
      S_CALC: begin
        if (alu_done) begin
          state_next = (c_we && last_e) ? S_IDLE : S_ISSUE;
        end
      end
      S_OUT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign adv      = ((state == S_DATA) && op_read && rsp_free)
                  || ((state == S_DATA) && op_test) || c_we;
  assign rsp_load = rsp_free && (((state == S_DATA) && op_read) || (state == S_OUT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_acc) begin
        i <= '0;
        j <= '0;
        k <= '0;
      end else if (adv) begin
        k <= '0;
        if (j == IMAX) begin
          j <= '0;
          i <= i + IW'(1);
        end else begin
          j <= j + IW'(1);
        end
      end else if ((state == S_CALC) && alu_done) begin
        k <= k + IW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      act   <= cmd.action;
      sel   <= cmd.which;
      val_w <= ld_data;
      acc   <= '0;
      ok    <= 1'b1;
    end else begin
      if ((state == S_DATA) && op_test) begin
        ok <= ok & pass;
      end
      if ((state == S_CALC) && alu_done) begin
        acc <= c_we ? '0 : alu_res;
      end
    end
    if (rsp_load) begin
      rsp.data <= (state == S_OUT) ? '0 : 32'(m0);
      rsp.flag <= (state == S_OUT) && ok;
      rsp.last <= (state == S_OUT) || last_e;
    end
  end

endmodule

`default_nettype wire

>>> sv/m3iu_checker.sv
`default_nettype none

module m3iu_checker (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_stall,
  input m3iu_pkg::cmd_t  cmd,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input m3iu_pkg::rsp_t  rsp
);

  import m3iu_pkg::*;

  // A result held back by the receiver stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  // A test answer carries zero data and closes its transaction.
  a_flag_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.flag |-> (rsp.data == 32'sd0) && rsp.last)
    else $error("flag set on a result that is not a test answer");

  // The command port opens right after reset.
  a_reset_open: assert property (@(posedge clk)
    rst |=> !cmd_stall)
    else $error("command port not open after reset");

  // An element load leaves the command port open.
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && ((cmd.action == ACT_LOAD_A) || (cmd.action == ACT_LOAD_B))
    |=> !cmd_stall)
    else $error("command port closed after an element load");

  // A read-out closes the command port once it is accepted.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.action == ACT_READ) |=> cmd_stall)
    else $error("command port open during a read-out");

endmodule

bind matrix_3x3_integer_unit m3iu_checker u_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import m3iu_pkg::*;

  localparam int DIM = 3;
  localparam int NELEM = DIM * DIM;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_C_ALIAS = 2'd3;
  localparam logic [3:0] ACT_SPARE_MIN = ACT_SYMM + 4'd1;
  localparam logic [3:0] ACT_SPARE_MAX = 4'd15;
  localparam int RANDOM_COMMANDS = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT = 500000;

  // Shadow copy of the three matrices plus the queue of responses they imply.
  class matrix_mirror;
    logic [31:0] mat_a[NELEM];
    logic [31:0] mat_b[NELEM];
    logic [31:0] mat_c[NELEM];
    rsp_t pending_responses[$];
    int errors;
    int commands_seen;
    int responses_checked;

    function new();
      for (int i = 0; i < NELEM; i++) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
        mat_c[i] = '0;
      end
      errors = 0;
      commands_seen = 0;
      responses_checked = 0;
    endfunction

    function logic [31:0] element(logic [1:0] sel, int idx);
      if (sel == SEL_A) begin
        return mat_a[idx];
      end else if (sel == SEL_B) begin
        return mat_b[idx];
      end
      return mat_c[idx];
    endfunction

    function bit has_property(logic [3:0] kind, logic [1:0] sel);
      bit ok;
      logic [31:0] e;
      ok = 1'b1;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          e = element(sel, i * DIM + j);
          case (kind)
            ACT_DIAG: if (i != j && e != 32'd0) ok = 1'b0;
            ACT_IDENT: if ((i == j) ? (e != 32'd1) : (e != 32'd0)) ok = 1'b0;
            default: if (e != element(sel, j * DIM + i)) ok = 1'b0;
          endcase
        end
      end
      return ok;
    endfunction

    function void note_command(cmd_t c);
      logic [31:0] acc;
      rsp_t r;
      commands_seen++;
      case (c.action)
        ACT_LOAD_A: if (c.row < DIM && c.col < DIM) mat_a[c.row * DIM + c.col] = c.value;
        ACT_LOAD_B: if (c.row < DIM && c.col < DIM) mat_b[c.row * DIM + c.col] = c.value;
        ACT_ADD: for (int i = 0; i < NELEM; i++) mat_c[i] = mat_a[i] + mat_b[i];
        ACT_SUB: for (int i = 0; i < NELEM; i++) mat_c[i] = mat_a[i] - mat_b[i];
        ACT_SCALE_A: for (int i = 0; i < NELEM; i++) mat_c[i] = c.value * mat_a[i];
        ACT_SCALE_B: for (int i = 0; i < NELEM; i++) mat_c[i] = c.value * mat_b[i];
        ACT_MUL: begin
          for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
              acc = '0;
              for (int k = 0; k < DIM; k++) begin
                acc = acc + mat_a[i * DIM + k] * mat_b[k * DIM + j];
              end
              mat_c[i * DIM + j] = acc;
            end
          end
        end
        ACT_TRANS_A, ACT_TRANS_B: begin
          for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
              mat_c[i * DIM + j] = (c.action == ACT_TRANS_A) ? mat_a[j * DIM + i]
                                                             : mat_b[j * DIM + i];
            end
          end
        end
        ACT_READ: begin
          for (int i = 0; i < NELEM; i++) begin
            r.data = element(c.which, i);
            r.flag = 1'b0;
            r.last = (i == NELEM - 1);
            pending_responses.push_back(r);
          end
        end
        ACT_DIAG, ACT_IDENT, ACT_SYMM: begin
          r.data = '0;
          r.flag = has_property(c.action, c.which);
          r.last = 1'b1;
          pending_responses.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses_checked++;
      if (pending_responses.size() == 0) begin
        $error("response with nothing pending: data=%0d flag=%0b last=%0b",
               got.data, got.flag, got.last);
        errors++;
        return;
      end
      want = pending_responses.pop_front();
      if (got.data !== want.data) begin
        $error("data mismatch: expected %0d, actual %0d", want.data, got.data);
        errors++;
      end
      if (got.flag !== want.flag) begin
        $error("flag mismatch: expected %0b, actual %0b", want.flag, got.flag);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  matrix_mirror mirror = new();
  bit hold_request = 1'b0;
  bit no_idle = 1'b0;
  int counted_commands = 0;
  int cycle_count = 0;

  matrix_3x3_integer_unit DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Responses are checked before the same edge's command is noted; a command
  // can never produce a response at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) mirror.check_response(rsp);
      if (cmd_valid && !cmd_stall) mirror.note_command(cmd);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL matrix_3x3_integer_unit");
    $finish;
  end

  // Response side: random stall before each transaction, plus one long hold-off.
  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  function automatic cmd_t make_cmd(logic [3:0] action, logic [1:0] which,
                                    logic [1:0] row, logic [1:0] col,
                                    logic [31:0] value);
    cmd_t c;
    c.action = action;
    c.which = which;
    c.row = row;
    c.col = col;
    c.value = value;
    return c;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick2(int lo, int hi);
    return 2'($urandom_range(lo, hi));
  endfunction

  function automatic logic [3:0] pick_act(logic [3:0] lo, logic [3:0] hi);
    return 4'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  task automatic drive_command(input cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    // Ignored transactions do not count toward the random budget.
    if (c.action <= ACT_SYMM &&
        !((c.action == ACT_LOAD_A || c.action == ACT_LOAD_B) &&
          (c.row >= DIM || c.col >= DIM))) begin
      counted_commands++;
    end
  endtask

  // Waiting starts on the next edge so the monitor has seen the last transaction.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending_responses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [3:0] load_act, input int kind);
    logic [31:0] grid[NELEM];
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        case (kind)
          0: grid[i * DIM + j] = (i == j) ? 32'd1 : 32'd0;
          1: grid[i * DIM + j] = (i == j) ? pick_value() : 32'd0;
          2: grid[i * DIM + j] = (j < i) ? grid[j * DIM + i] : pick_value();
          default: grid[i * DIM + j] = pick_value();
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0) grid[$urandom_range(0, NELEM - 1)] = pick_value();
    for (int idx = 0; idx < NELEM; idx++) begin
      drive_command(make_cmd(load_act, pick2(0, 3), 2'(idx / DIM), 2'(idx % DIM),
                             grid[idx]));
    end
  endtask

  initial begin
    logic [3:0] act;
    logic [3:0] load_act;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    drive_command(make_cmd(ACT_READ, SEL_A, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_DIAG, SEL_A, 2'd3, 2'd3, 32'hFFFF_FFFF));
    drive_command(make_cmd(ACT_LOAD_A, SEL_A, 2'd0, 2'd0, 32'h7FFF_FFFF));
    drive_command(make_cmd(ACT_LOAD_A, SEL_C_ALIAS, 2'd2, 2'd2, 32'h8000_0000));
    drive_command(make_cmd(ACT_LOAD_A, SEL_A, 2'd0, 2'd1, 32'hFFFF_FFFF));
    drive_command(make_cmd(ACT_LOAD_B, SEL_B, 2'd1, 2'd1, 32'd1));
    drive_command(make_cmd(ACT_LOAD_B, SEL_B, 2'd2, 2'd0, 32'd3));
    // Out-of-range load indexes leave every matrix untouched.
    drive_command(make_cmd(ACT_LOAD_A, SEL_A, 2'd3, 2'd1, 32'd5));
    drive_command(make_cmd(ACT_LOAD_B, SEL_B, 2'd1, 2'd3, 32'd7));
    drive_command(make_cmd(ACT_ADD, SEL_A, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_READ, SEL_C_ALIAS, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_SUB, SEL_A, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_IDENT, SEL_C, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_SCALE_A, SEL_A, 2'd0, 2'd0, 32'h8000_0000));
    drive_command(make_cmd(ACT_READ, SEL_C, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_SCALE_B, SEL_B, 2'd0, 2'd0, 32'hFFFF_FFFF));
    drive_command(make_cmd(ACT_READ, SEL_B, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_MUL, SEL_A, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_READ, SEL_C, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_TRANS_A, SEL_A, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_SYMM, SEL_C, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_TRANS_B, SEL_B, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_DIAG, SEL_C_ALIAS, 2'd0, 2'd0, 32'd0));
    drive_command(make_cmd(ACT_SPARE_MAX, SEL_C_ALIAS, 2'd3, 2'd3, 32'hFFFF_FFFF));
    drive_command(make_cmd(ACT_IDENT, SEL_B, 2'd0, 2'd0, 32'd0));

    // Hold the response side off while reads keep arriving, so the unit backs up.
    hold_request = 1'b1;
    repeat (5) drive_command(make_cmd(ACT_READ, pick2(0, 3), 2'd0, 2'd0, 32'd0));
    wait_drained();

    counted_commands = 0;
    while (counted_commands < RANDOM_COMMANDS) begin
      no_idle = (counted_commands >= 150 && counted_commands < 190);
      if (!drained_mid && counted_commands >= 100) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          load_act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
          load_pattern(load_act, $urandom_range(0, 3));
          drive_command(make_cmd(pick_act(ACT_DIAG, ACT_SYMM),
                                 (load_act == ACT_LOAD_A) ? SEL_A : SEL_B,
                                 pick2(0, 3), pick2(0, 3), $urandom));
        end
        2, 3: begin
          load_act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
          drive_command(make_cmd(load_act, pick2(0, 3),
                                 pick2(0, 2), pick2(0, 2), pick_value()));
        end
        4, 5: begin
          drive_command(make_cmd(pick_act(ACT_ADD, ACT_TRANS_B), pick2(0, 3),
                                 pick2(0, 3), pick2(0, 3), pick_value()));
          act = $urandom_range(0, 1) ? ACT_READ : pick_act(ACT_DIAG, ACT_SYMM);
          drive_command(make_cmd(act, $urandom_range(0, 1) ? SEL_C : SEL_C_ALIAS,
                                 pick2(0, 3), pick2(0, 3), $urandom));
        end
        6: drive_command(make_cmd(ACT_READ, pick2(0, 3), pick2(0, 3),
                                  pick2(0, 3), $urandom));
        7: drive_command(make_cmd(pick_act(ACT_DIAG, ACT_SYMM), pick2(0, 3),
                                  pick2(0, 3), pick2(0, 3), $urandom));
        8: begin
          if ($urandom_range(0, 1)) begin
            drive_command(make_cmd(pick_act(ACT_SPARE_MIN, ACT_SPARE_MAX),
                                   pick2(0, 3), pick2(0, 3),
                                   pick2(0, 3), $urandom));
          end else begin
            // Broken load: at least one index past the last row or column.
            drive_command(make_cmd($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A,
                                   pick2(0, 3), 2'd3, pick2(0, 3),
                                   $urandom));
          end
        end
        default: drive_command(make_cmd(pick_act(ACT_ADD, ACT_TRANS_B),
                                        pick2(0, 3), pick2(0, 3),
                                        pick2(0, 3), pick_value()));
      endcase
    end

    no_idle = 1'b0;
    wait_drained();
    $display("Covered %0d command transactions and %0d response transactions:",
             mirror.commands_seen, mirror.responses_checked);
    $display("loads, all arithmetic and transpose operations, read-outs and matrix tests.");
    if (mirror.errors == 0) begin
      $display("PASS matrix_3x3_integer_unit");
    end else begin
      $display("FAIL matrix_3x3_integer_unit");
    end
    $finish;
  end

endmodule
